// ===== src/v3a_pkg.sv =====
// Shared types and operation codes for the 3D vector arithmetic unit.
package v3a_pkg;

    localparam int MODE_BITS = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD   = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_SCALE = 3'd2,
        MODE_DIV   = 3'd3,
        MODE_DOT   = 3'd4,
        MODE_CROSS = 3'd5,
        MODE_MOD   = 3'd6,
        MODE_NORM  = 3'd7
    } v3a_mode_t;

endpackage

// ===== src/v3a_cmd_if.sv =====
// Input item channel: mode, two vectors and a scalar.
interface v3a_cmd_if
    import v3a_pkg::*;
#(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [MODE_BITS-1:0]        mode;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] scale;

    modport source (output valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale, input ready);
    modport sink   (input valid, mode, a_x, a_y, a_z, b_x, b_y, b_z, scale, output ready);
endinterface

// ===== src/v3a_res_if.sv =====
// Result item channel: vector, scalar and flags.
interface v3a_res_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] r_scalar;
    logic                        div_zero;
    logic                        overflow;

    modport source (output valid, r_x, r_y, r_z, r_scalar, div_zero, overflow, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_scalar, div_zero, overflow, output ready);
endinterface

// ===== src/vector3_arith_unit_top.sv =====
// Top level of the 3D vector arithmetic unit: front end, root row, divider row.
//
//  channel  dir  handshake      carries
//  cmd      in   valid/ready    mode, a_x..a_z, b_x..b_z, scale
//  res      out  valid/ready    r_x, r_y, r_z, r_scalar, div_zero, overflow
//
// One item enters per cycle while the row is not stalled; every item runs through
// the whole row: two front stages, WORD_BITS root cells, one setup stage,
// WORD_BITS+FRAC_BITS divider cells and the output register.
// rst_n clears every stage valid bit at once; data registers are not reset.
// A result held in the output register and not taken stalls the whole row.
module vector3_arith_unit_top
    import v3a_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    v3a_cmd_if.sink   cmd,
    v3a_res_if.source res
);
    localparam int W      = WORD_BITS;
    localparam int F      = FRAC_BITS;
    localparam int PW     = 2 * W;
    localparam int QW     = W + F;
    localparam int SIDE_W = 4 * W + 2;
    localparam int PAY_W  = MODE_BITS + 4 * W + SIDE_W;
    localparam int DPAY_W = SIDE_W + 1;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    logic                    en;

    // Front end outputs
    logic                    f_valid;
    logic [MODE_BITS-1:0]    f_mode;
    logic [2:0][W-1:0]       f_a;
    logic [W-1:0]            f_s;
    logic [SIDE_W-1:0]       f_side;
    logic [PW-1:0]           f_sq;

    // Root row
    logic [W:0]              sq_valid;
    logic [W:0][PW-1:0]      sq_rad;
    logic [W:0][W+1:0]       sq_rem;
    logic [W:0][W-1:0]       sq_root;
    logic [W:0][PAY_W-1:0]   sq_pay;

    // Setup between the rows
    logic [MODE_BITS-1:0]    m_mode;
    logic [2:0][W-1:0]       m_a;
    logic [W-1:0]            m_s;
    logic [SIDE_W-1:0]       m_side;
    logic [W-1:0]            m_root;
    logic [3:0][W-1:0]       set_r;
    logic                    set_ov;
    logic                    set_dz;
    logic                    set_use;
    logic [W-1:0]            set_div;
    logic [2:0]              set_neg;
    logic [2:0][QW-1:0]      set_num;
    logic [W-1:0]            abs_a;

    // Divider row
    logic [QW:0]                    dv_valid;
    logic [QW:0][W-1:0]             dv_div;
    logic [QW:0][2:0]               dv_neg;
    logic [QW:0][2:0][QW-1:0]       dv_shr;
    logic [QW:0][2:0][W-1:0]        dv_rem;
    logic [QW:0][DPAY_W-1:0]        dv_pay;

    // Output stage
    logic [3:0][W-1:0]       fin_r;
    logic                    fin_ov;
    logic [QW-1:0]           qv;
    logic [W-1:0]            qval;
    logic                    q_ov;
    logic                    res_valid_reg;
    logic [W-1:0]            res_rx_reg;
    logic [W-1:0]            res_ry_reg;
    logic [W-1:0]            res_rz_reg;
    logic [W-1:0]            res_rs_reg;
    logic                    res_dz_reg;
    logic                    res_ov_reg;

    // Advance the whole row whenever the output register is free or being taken
    assign en = !res_valid_reg || res.ready;

    v3a_front #(.WORD_BITS(W), .FRAC_BITS(F)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cmd   (cmd),
        .valid (f_valid),
        .mode  (f_mode),
        .a     (f_a),
        .s     (f_s),
        .side  (f_side),
        .sq    (f_sq)
    );

    // Root row: one root bit per cell, sum of squares enters at the top
    assign sq_valid[0] = f_valid;
    assign sq_rad[0]   = f_sq;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_pay[0]   = {f_side, f_s, f_a, f_mode};

    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        if (i == W - 1)
        begin : g_last
            v3a_sqrt_cell #(.WORD_BITS(W), .PAY_BITS(PAY_W)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (sq_valid[i]),
                .rad_i   (sq_rad[i]),
                .rem_i   (sq_rem[i]),
                .root_i  (sq_root[i]),
                .pay_i   (sq_pay[i]),
                .valid_o (sq_valid[i+1]),
                .rad_o   (),
                .rem_o   (),
                .root_o  (sq_root[i+1]),
                .pay_o   (sq_pay[i+1])
            );
        end
        else
        begin : g_mid
            v3a_sqrt_cell #(.WORD_BITS(W), .PAY_BITS(PAY_W)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (sq_valid[i]),
                .rad_i   (sq_rad[i]),
                .rem_i   (sq_rem[i]),
                .root_i  (sq_root[i]),
                .pay_i   (sq_pay[i]),
                .valid_o (sq_valid[i+1]),
                .rad_o   (sq_rad[i+1]),
                .rem_o   (sq_rem[i+1]),
                .root_o  (sq_root[i+1]),
                .pay_o   (sq_pay[i+1])
            );
        end
    end

    assign m_root = sq_root[W];
    assign {m_side, m_s, m_a, m_mode} = sq_pay[W];

    // Set up the divider: divisor magnitude, result signs, shifted numerators
    always_comb
    begin
        set_r   = m_side[4*W-1:0];
        set_dz  = m_side[4*W];
        set_ov  = m_side[4*W+1];
        set_use = 1'b0;
        set_div = m_root;
        abs_a   = '0;
        for (int k = 0; k < 3; k++)
            set_neg[k] = m_a[k][W-1];
        case (v3a_mode_t'(m_mode))
            MODE_DIV:
            begin
                set_use = (m_s != '0);
                set_div = m_s[W-1] ? W'(-m_s) : m_s;
                for (int k = 0; k < 3; k++)
                    set_neg[k] = m_a[k][W-1] ^ m_s[W-1];
            end
            MODE_MOD:
            begin
                set_r[3] = m_root[W-1] ? SAT_MAX : m_root;
                set_ov   = m_root[W-1];
            end
            MODE_NORM:
            begin
                // Zero vector passes through unchanged
                if (m_root == '0)
                begin
                    for (int k = 0; k < 3; k++)
                        set_r[k] = m_a[k];
                end
                else
                    set_use = 1'b1;
            end
            default:
                set_use = 1'b0;
        endcase
        for (int k = 0; k < 3; k++)
        begin
            abs_a = m_a[k][W-1] ? W'(-m_a[k]) : m_a[k];
            set_num[k] = {abs_a, {F{1'b0}}};
        end
    end

    logic                 st_valid_reg;
    logic [W-1:0]         st_div_reg;
    logic [2:0]           st_neg_reg;
    logic [2:0][QW-1:0]   st_num_reg;
    logic [DPAY_W-1:0]    st_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (en)
            st_valid_reg <= sq_valid[W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_div_reg <= set_div;
            st_neg_reg <= set_neg;
            st_num_reg <= set_num;
            st_pay_reg <= {set_use, set_ov, set_dz, set_r};
        end
    end

    // Divider row: one quotient bit per cell for all three lanes
    assign dv_valid[0] = st_valid_reg;
    assign dv_div[0]   = st_div_reg;
    assign dv_neg[0]   = st_neg_reg;
    assign dv_shr[0]   = st_num_reg;
    assign dv_rem[0]   = '0;
    assign dv_pay[0]   = st_pay_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        if (i == QW - 1)
        begin : g_last
            v3a_div_cell #(.WORD_BITS(W), .FRAC_BITS(F), .PAY_BITS(DPAY_W)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (dv_valid[i]),
                .div_i   (dv_div[i]),
                .neg_i   (dv_neg[i]),
                .shr_i   (dv_shr[i]),
                .rem_i   (dv_rem[i]),
                .pay_i   (dv_pay[i]),
                .valid_o (dv_valid[i+1]),
                .div_o   (),
                .neg_o   (dv_neg[i+1]),
                .shr_o   (dv_shr[i+1]),
                .rem_o   (),
                .pay_o   (dv_pay[i+1])
            );
        end
        else
        begin : g_mid
            v3a_div_cell #(.WORD_BITS(W), .FRAC_BITS(F), .PAY_BITS(DPAY_W)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (dv_valid[i]),
                .div_i   (dv_div[i]),
                .neg_i   (dv_neg[i]),
                .shr_i   (dv_shr[i]),
                .rem_i   (dv_rem[i]),
                .pay_i   (dv_pay[i]),
                .valid_o (dv_valid[i+1]),
                .div_o   (dv_div[i+1]),
                .neg_o   (dv_neg[i+1]),
                .shr_o   (dv_shr[i+1]),
                .rem_o   (dv_rem[i+1]),
                .pay_o   (dv_pay[i+1])
            );
        end
    end

    // Sign and saturate the quotients; keep the early results otherwise
    always_comb
    begin
        fin_r  = dv_pay[QW][4*W-1:0];
        fin_ov = dv_pay[QW][4*W+1];
        qv     = '0;
        qval   = '0;
        q_ov   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            qv   = dv_shr[QW][k];
            qval = dv_neg[QW][k] ? W'(-qv[W-1:0]) : qv[W-1:0];
            if (dv_neg[QW][k])
                q_ov = (|qv[QW-1:W]) || (qv[W-1] && (|qv[W-2:0]));
            else
                q_ov = |qv[QW-1:W-1];
            if (dv_pay[QW][4*W+2])
            begin
                fin_r[k] = q_ov ? (dv_neg[QW][k] ? SAT_MIN : SAT_MAX) : qval;
                fin_ov   = fin_ov | q_ov;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dv_valid[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_rx_reg <= fin_r[0];
            res_ry_reg <= fin_r[1];
            res_rz_reg <= fin_r[2];
            res_rs_reg <= fin_r[3];
            res_dz_reg <= dv_pay[QW][4*W];
            res_ov_reg <= fin_ov;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.r_x      = res_rx_reg;
    assign res.r_y      = res_ry_reg;
    assign res.r_z      = res_rz_reg;
    assign res.r_scalar = res_rs_reg;
    assign res.div_zero = res_dz_reg;
    assign res.overflow = res_ov_reg;

`ifndef SYNTHESIS
    // Input is held back only by a waiting, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (res.valid && !res.ready))
        else $error("input stalled without a blocked result");

    // Divide by zero yields an all-zero result and no overflow
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.div_zero) |->
        (res.r_x == '0 && res.r_y == '0 && res.r_z == '0 && res.r_scalar == '0
         && !res.overflow))
        else $error("divide by zero result not cleared");

    // A scalar result leaves the vector fields clear
    a_scalar_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.r_scalar != '0) |->
        (res.r_x == '0 && res.r_y == '0 && res.r_z == '0 && !res.div_zero))
        else $error("scalar and vector results both set");

    // A stalled row holds the item in the last divider cell
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_valid[QW]))
        else $error("divider row advanced during stall");
`endif

endmodule

// ===== src/v3a_front.sv =====
// Front end: products, sums and early results for the non-iterative modes.
module v3a_front
    import v3a_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    v3a_cmd_if.sink                           cmd,
    output logic                              valid,
    output logic [MODE_BITS-1:0]              mode,
    output logic [2:0][WORD_BITS-1:0]         a,
    output logic [WORD_BITS-1:0]              s,
    output logic [4*WORD_BITS+1:0]            side,
    output logic [2*WORD_BITS-1:0]            sq
);
    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
        logic o;
        o = !(&v[SW-1:W-1]) && (|v[SW-1:W-1]);
        return {o, o ? (v[SW-1] ? SAT_MIN : SAT_MAX) : v[W-1:0]};
    endfunction

    logic [2:0][W-1:0]           a_in;
    logic [2:0][W-1:0]           b_in;
    logic signed [W-1:0]         ml [3];
    logic signed [W-1:0]         mr [3];
    logic signed [W-1:0]         nl [3];
    logic signed [W-1:0]         nr [3];
    logic signed [PW-1:0]        p_next [3];
    logic signed [PW-1:0]        q_next [3];
    logic signed [W:0]           as_next [3];

    logic                        s1_valid_reg;
    logic [MODE_BITS-1:0]        s1_mode_reg;
    logic [2:0][W-1:0]           s1_a_reg;
    logic [W-1:0]                s1_s_reg;
    logic signed [W:0]           s1_as_reg [3];
    logic signed [PW-1:0]        s1_p_reg [3];
    logic signed [PW-1:0]        s1_q_reg [3];

    logic signed [SW-1:0]        sum3;
    logic [3:0][W-1:0]           r_next;
    logic                        ov_next;
    logic                        dz_next;

    logic                        s2_valid_reg;
    logic [MODE_BITS-1:0]        s2_mode_reg;
    logic [2:0][W-1:0]           s2_a_reg;
    logic [W-1:0]                s2_s_reg;
    logic [4*W+1:0]              s2_side_reg;
    logic [PW-1:0]               s2_sq_reg;

    assign cmd.ready = en;
    assign a_in = {cmd.a_z, cmd.a_y, cmd.a_x};
    assign b_in = {cmd.b_z, cmd.b_y, cmd.b_x};

    // Pick multiplier operands by mode; cross uses the second bank too.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ml[k] = a_in[k];
            mr[k] = a_in[k];
            nl[k] = a_in[(k + 2) % 3];
            nr[k] = b_in[(k + 1) % 3];
            case (v3a_mode_t'(cmd.mode))
                MODE_SCALE: mr[k] = cmd.scale;
                MODE_DOT:   mr[k] = b_in[k];
                MODE_CROSS:
                begin
                    ml[k] = a_in[(k + 1) % 3];
                    mr[k] = b_in[(k + 2) % 3];
                end
                default:    mr[k] = a_in[k];
            endcase
            p_next[k] = PW'(ml[k]) * PW'(mr[k]);
            q_next[k] = PW'(nl[k]) * PW'(nr[k]);
            if (v3a_mode_t'(cmd.mode) == MODE_SUB)
                as_next[k] = (W+1)'($signed(a_in[k])) - (W+1)'($signed(b_in[k]));
            else
                as_next[k] = (W+1)'($signed(a_in[k])) + (W+1)'($signed(b_in[k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mode_reg <= cmd.mode;
            s1_a_reg    <= a_in;
            s1_s_reg    <= cmd.scale;
            for (int k = 0; k < 3; k++)
            begin
                s1_as_reg[k] <= as_next[k];
                s1_p_reg[k]  <= p_next[k];
                s1_q_reg[k]  <= q_next[k];
            end
        end
    end

    // Shift, saturate and select the results that need no iteration.
    always_comb
    begin
        logic [W:0] st;
        sum3    = SW'(s1_p_reg[0]) + SW'(s1_p_reg[1]) + SW'(s1_p_reg[2]);
        r_next  = '0;
        ov_next = 1'b0;
        dz_next = 1'b0;
        st      = '0;
        case (v3a_mode_t'(s1_mode_reg))
            MODE_ADD, MODE_SUB:
                for (int k = 0; k < 3; k++)
                begin
                    st = sat_fn(SW'(s1_as_reg[k]));
                    r_next[k] = st[W-1:0];
                    ov_next = ov_next | st[W];
                end
            MODE_SCALE:
                for (int k = 0; k < 3; k++)
                begin
                    st = sat_fn(SW'(s1_p_reg[k]) >>> F);
                    r_next[k] = st[W-1:0];
                    ov_next = ov_next | st[W];
                end
            MODE_DIV:
                dz_next = (s1_s_reg == '0);
            MODE_DOT:
            begin
                st = sat_fn(sum3 >>> F);
                r_next[3] = st[W-1:0];
                ov_next = st[W];
            end
            MODE_CROSS:
                for (int k = 0; k < 3; k++)
                begin
                    st = sat_fn((SW'(s1_p_reg[k]) - SW'(s1_q_reg[k])) >>> F);
                    r_next[k] = st[W-1:0];
                    ov_next = ov_next | st[W];
                end
            default:
                st = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_a_reg    <= s1_a_reg;
            s2_s_reg    <= s1_s_reg;
            s2_side_reg <= {ov_next, dz_next, r_next};
            s2_sq_reg   <= sum3[PW-1:0];
        end
    end

    assign valid = s2_valid_reg;
    assign mode  = s2_mode_reg;
    assign a     = s2_a_reg;
    assign s     = s2_s_reg;
    assign side  = s2_side_reg;
    assign sq    = s2_sq_reg;

endmodule

// ===== src/v3a_sqrt_cell.sv =====
// One square root cell: settles one root bit from two radicand bits.
module v3a_sqrt_cell #(
    parameter int WORD_BITS = 32,
    parameter int PAY_BITS  = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_i,
    input  logic [2*WORD_BITS-1:0] rad_i,
    input  logic [WORD_BITS+1:0]   rem_i,
    input  logic [WORD_BITS-1:0]   root_i,
    input  logic [PAY_BITS-1:0]    pay_i,
    output logic                   valid_o,
    output logic [2*WORD_BITS-1:0] rad_o,
    output logic [WORD_BITS+1:0]   rem_o,
    output logic [WORD_BITS-1:0]   root_o,
    output logic [PAY_BITS-1:0]    pay_o
);
    localparam int W = WORD_BITS;

    logic [W+1:0]   rem_sh;
    logic [W+1:0]   trial;
    logic           ge;
    logic           valid_reg;
    logic [2*W-1:0] rad_reg;
    logic [W+1:0]   rem_reg;
    logic [W-1:0]   root_reg;
    logic [PAY_BITS-1:0] pay_reg;

    assign rem_sh = {rem_i[W-1:0], rad_i[2*W-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= {rad_i[2*W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_i[W-2:0], ge};
            pay_reg  <= pay_i;
        end
    end

    assign valid_o = valid_reg;
    assign rad_o   = rad_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign pay_o   = pay_reg;

endmodule

// ===== src/v3a_div_cell.sv =====
// One divider cell: settles one quotient bit for each of three lanes.
module v3a_div_cell #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int PAY_BITS  = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  valid_i,
    input  logic [WORD_BITS-1:0]                  div_i,
    input  logic [2:0]                            neg_i,
    input  logic [2:0][WORD_BITS+FRAC_BITS-1:0]   shr_i,
    input  logic [2:0][WORD_BITS-1:0]             rem_i,
    input  logic [PAY_BITS-1:0]                   pay_i,
    output logic                                  valid_o,
    output logic [WORD_BITS-1:0]                  div_o,
    output logic [2:0]                            neg_o,
    output logic [2:0][WORD_BITS+FRAC_BITS-1:0]   shr_o,
    output logic [2:0][WORD_BITS-1:0]             rem_o,
    output logic [PAY_BITS-1:0]                   pay_o
);
    localparam int W  = WORD_BITS;
    localparam int QW = WORD_BITS + FRAC_BITS;

    logic [W:0]              rs [3];
    logic [W:0]              df [3];
    logic [2:0]              ge;
    logic                    valid_reg;
    logic [W-1:0]            div_reg;
    logic [2:0]              neg_reg;
    logic [2:0][QW-1:0]      shr_reg;
    logic [2:0][W-1:0]       rem_reg;
    logic [PAY_BITS-1:0]     pay_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rs[k] = {rem_i[k], shr_i[k][QW-1]};
            df[k] = rs[k] - {1'b0, div_i};
            ge[k] = (rs[k] >= {1'b0, div_i});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_i;
            neg_reg <= neg_i;
            pay_reg <= pay_i;
            for (int k = 0; k < 3; k++)
            begin
                shr_reg[k] <= {shr_i[k][QW-2:0], ge[k]};
                rem_reg[k] <= ge[k] ? df[k][W-1:0] : rs[k][W-1:0];
            end
        end
    end

    assign valid_o = valid_reg;
    assign div_o   = div_reg;
    assign neg_o   = neg_reg;
    assign shr_o   = shr_reg;
    assign rem_o   = rem_reg;
    assign pay_o   = pay_reg;

endmodule
